>>> sv/dptt_pkg.sv
// dptt_pkg: shared types and constants for the depth-preferred transposition table
// request and bound codes, queue item layout, back-end state encoding
// no dependencies
package dptt_pkg;

    // request codes on req_type
    localparam logic [1:0] REQ_STORE = 2'd0;
    localparam logic [1:0] REQ_LOAD  = 2'd1;
    localparam logic [1:0] REQ_CLEAR = 2'd2;
    localparam logic [1:0] REQ_NOP   = 2'd3;

    // bound kinds held with a stored score
    localparam logic [1:0] BOUND_EXACT = 2'd0;
    localparam logic [1:0] BOUND_ALPHA = 2'd1;
    localparam logic [1:0] BOUND_BETA  = 2'd2;

    // field widths
    localparam int SIG_W   = 32;
    localparam int DEPTH_W = 8;
    localparam int BOUND_W = 2;
    localparam int SCORE_W = 16;
    localparam int MOVE_W  = 32;

    // tag word: valid bit over signature
    localparam int TAG_W = SIG_W + 1;

    // info word: depth, bound kind, score
    localparam int INFO_W         = DEPTH_W + BOUND_W + SCORE_W;
    localparam int INFO_BOUND_LSB = SCORE_W;
    localparam int INFO_DEPTH_LSB = SCORE_W + BOUND_W;

    // data word: move over info
    localparam int DATA_W = MOVE_W + INFO_W;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // operation carried through the queue
    typedef enum logic [1:0] {
        OP_STORE,
        OP_LOAD,
        OP_CLEAR
    } op_t;

    // back-end sequencer states
    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_EXEC
    } back_state_t;

    // one queued request, table index travels beside it
    typedef struct packed {
        op_t                       op;
        logic [SIG_W-1:0]          sig;
        logic [DEPTH_W-1:0]        depth;
        logic [BOUND_W-1:0]        bound;
        logic signed [SCORE_W-1:0] score;
        logic [MOVE_W-1:0]         move;
        logic signed [SCORE_W-1:0] alpha;
        logic signed [SCORE_W-1:0] beta;
    } item_t;

endpackage

>>> sv/depth_preferred_transposition_table_unit.sv
// depth-preferred transposition table, direct-mapped on the low key bits
// a load result is registered after the queue slot, the BK_IDLE read and the BK_EXEC probe
// a store or load runs an entry read, then an entry write or result, before the next is popped
// a clear request sweeps every entry in BK_CLEAR, one entry written empty per cycle
// reset starts a clear sweep, busy stays high until it ends
// results show for one cycle on result_valid; the receiver cannot stall
module depth_preferred_transposition_table_unit #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [1:0]                          req_type,
    input  logic [63:0]                         pos_key,
    input  logic [dptt_pkg::SIG_W-1:0]          pos_signature,
    input  logic [dptt_pkg::DEPTH_W-1:0]        search_depth,
    input  logic [dptt_pkg::BOUND_W-1:0]        bound_kind,
    input  logic signed [dptt_pkg::SCORE_W-1:0] score,
    input  logic [dptt_pkg::MOVE_W-1:0]         best_move,
    input  logic signed [dptt_pkg::SCORE_W-1:0] alpha_bound,
    input  logic signed [dptt_pkg::SCORE_W-1:0] beta_bound,
    output logic                                result_valid,
    output logic                                score_known,
    output logic signed [dptt_pkg::SCORE_W-1:0] result_score,
    output logic                                move_known,
    output logic [dptt_pkg::MOVE_W-1:0]         hash_move
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int Q_W   = IDX_W + $bits(dptt_pkg::item_t);

    logic           push;
    logic [Q_W-1:0] push_data;
    logic           pop;
    logic [Q_W-1:0] head_data;
    logic           q_empty;
    logic           q_full;
    logic           clearing;

    // request intake
    dptt_front #(
        .IDX_W (IDX_W)
    ) u_front (
        .start         (start),
        .busy          (busy),
        .req_type      (req_type),
        .pos_key       (pos_key),
        .pos_signature (pos_signature),
        .search_depth  (search_depth),
        .bound_kind    (bound_kind),
        .score         (score),
        .best_move     (best_move),
        .alpha_bound   (alpha_bound),
        .beta_bound    (beta_bound),
        .q_full        (q_full),
        .clearing      (clearing),
        .push          (push),
        .push_data     (push_data)
    );

    // request queue
    dptt_queue #(
        .WIDTH (Q_W)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head_data (head_data),
        .empty     (q_empty),
        .full      (q_full)
    );

    // table sequencer
    dptt_back #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_data       (head_data),
        .q_pop        (pop),
        .clearing     (clearing),
        .result_valid (result_valid),
        .score_known  (score_known),
        .result_score (result_score),
        .move_known   (move_known),
        .hash_move    (hash_move)
    );

    // no transfer into a full queue
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_full))
        else $error("request pushed into full queue");

    // every load needs an entry read in BK_IDLE first, so results never come back to back
    a_result_spacing: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("results on consecutive cycles");

    // nothing comes out while a clear sweep runs
    a_no_result_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clearing |-> !result_valid)
        else $error("result during clear sweep");

endmodule

>>> sv/dptt_ram.sv
// dptt_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module dptt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> sv/dptt_front.sv
// dptt_front: request intake, classifies each request and forms the queue item
// depends on dptt_pkg
module dptt_front #(
    parameter int IDX_W = 12
) (
    input  logic                                  start,
    output logic                                  busy,
    input  logic [1:0]                            req_type,
    input  logic [63:0]                           pos_key,
    input  logic [dptt_pkg::SIG_W-1:0]            pos_signature,
    input  logic [dptt_pkg::DEPTH_W-1:0]          search_depth,
    input  logic [dptt_pkg::BOUND_W-1:0]          bound_kind,
    input  logic signed [dptt_pkg::SCORE_W-1:0]   score,
    input  logic [dptt_pkg::MOVE_W-1:0]           best_move,
    input  logic signed [dptt_pkg::SCORE_W-1:0]   alpha_bound,
    input  logic signed [dptt_pkg::SCORE_W-1:0]   beta_bound,
    input  logic                                  q_full,
    input  logic                                  clearing,
    output logic                                  push,
    output logic [IDX_W+$bits(dptt_pkg::item_t)-1:0] push_data
);

    logic            accept;
    logic            keep;
    dptt_pkg::op_t   op;
    dptt_pkg::item_t item;

    // hold off while the queue is full or a clear sweep runs
    assign busy   = q_full || clearing;
    assign accept = start && !busy;

    // classify the request, no-op requests are dropped here
    always_comb
    begin
        op   = dptt_pkg::OP_STORE;
        keep = 1'b0;
        unique case (req_type)
            dptt_pkg::REQ_STORE:
            begin
                op   = dptt_pkg::OP_STORE;
                keep = 1'b1;
            end
            dptt_pkg::REQ_LOAD:
            begin
                op   = dptt_pkg::OP_LOAD;
                keep = 1'b1;
            end
            dptt_pkg::REQ_CLEAR:
            begin
                op   = dptt_pkg::OP_CLEAR;
                keep = 1'b1;
            end
            dptt_pkg::REQ_NOP:
            begin
                op   = dptt_pkg::OP_STORE;
                keep = 1'b0;
            end
        endcase
    end

    // queue item, index is the low key bits
    always_comb
    begin
        item.op    = op;
        item.sig   = pos_signature;
        item.depth = search_depth;
        item.bound = bound_kind;
        item.score = score;
        item.move  = best_move;
        item.alpha = alpha_bound;
        item.beta  = beta_bound;
    end

    assign push      = accept && keep;
    assign push_data = {pos_key[IDX_W-1:0], item};

endmodule

>>> sv/dptt_queue.sv
// dptt_queue: short register queue between request intake and table sequencer
// depends on dptt_pkg
module dptt_queue #(
    parameter int WIDTH = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             empty,
    output logic             full
);

    localparam int PTR_W = $clog2(dptt_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(dptt_pkg::QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [dptt_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CNT_W'(dptt_pkg::QUEUE_DEPTH));
    assign head_data = slot_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        priority if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // slot storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> sv/dptt_back.sv
// dptt_back: table sequencer, runs stores, loads and clear sweeps on the table rams
// depends on dptt_pkg and dptt_ram
module dptt_back #(
    parameter int TABLE_ENTRIES = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                q_empty,
    input  logic [$clog2(TABLE_ENTRIES)+$bits(dptt_pkg::item_t)-1:0] q_data,
    output logic                                q_pop,
    output logic                                clearing,
    output logic                                result_valid,
    output logic                                score_known,
    output logic signed [dptt_pkg::SCORE_W-1:0] result_score,
    output logic                                move_known,
    output logic [dptt_pkg::MOVE_W-1:0]         hash_move
);

    localparam int IDX_W  = $clog2(TABLE_ENTRIES);
    localparam int ITEM_W = $bits(dptt_pkg::item_t);

    dptt_pkg::back_state_t state_reg;
    dptt_pkg::back_state_t state_next;
    logic [IDX_W-1:0]      clr_cnt_reg;
    logic [IDX_W-1:0]      clr_cnt_next;
    dptt_pkg::item_t       item_reg;
    dptt_pkg::item_t       item_next;
    logic [IDX_W-1:0]      idx_reg;
    logic [IDX_W-1:0]      idx_next;

    logic                                res_valid_reg;
    logic                                res_valid_next;
    logic                                score_known_reg;
    logic                                score_known_next;
    logic signed [dptt_pkg::SCORE_W-1:0] result_score_reg;
    logic signed [dptt_pkg::SCORE_W-1:0] result_score_next;
    logic                                move_known_reg;
    logic                                move_known_next;
    logic [dptt_pkg::MOVE_W-1:0]         hash_move_reg;
    logic [dptt_pkg::MOVE_W-1:0]         hash_move_next;

    dptt_pkg::item_t head_item;
    logic [IDX_W-1:0] head_idx;

    logic                        rd_en;
    logic                        tag_we;
    logic [IDX_W-1:0]            tag_waddr;
    logic [dptt_pkg::TAG_W-1:0]  tag_wdata;
    logic [dptt_pkg::TAG_W-1:0]  tag_rdata;
    logic                        data_we;
    logic [dptt_pkg::DATA_W-1:0] data_wdata;
    logic [dptt_pkg::DATA_W-1:0] data_rdata;

    logic                                held_valid;
    logic [dptt_pkg::SIG_W-1:0]          held_sig;
    logic [dptt_pkg::MOVE_W-1:0]         held_move;
    logic [dptt_pkg::DEPTH_W-1:0]        held_depth;
    logic [dptt_pkg::BOUND_W-1:0]        held_bound;
    logic signed [dptt_pkg::SCORE_W-1:0] held_score;
    logic                                store_wins;
    logic                                hit;
    logic                                deep;
    logic                                usable;
    logic signed [dptt_pkg::SCORE_W-1:0] usable_score;

    assign head_idx  = q_data[ITEM_W +: IDX_W];
    assign head_item = dptt_pkg::item_t'(q_data[ITEM_W-1:0]);
    assign clearing  = (state_reg == dptt_pkg::BK_CLEAR);

    // tag store: valid bit and signature
    dptt_ram #(
        .WIDTH (dptt_pkg::TAG_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_tag_ram (
        .clk   (clk),
        .we    (tag_we),
        .waddr (tag_waddr),
        .wdata (tag_wdata),
        .re    (rd_en),
        .raddr (head_idx),
        .rdata (tag_rdata)
    );

    // data store: move, depth, bound kind, score
    dptt_ram #(
        .WIDTH (dptt_pkg::DATA_W),
        .DEPTH (TABLE_ENTRIES)
    ) u_data_ram (
        .clk   (clk),
        .we    (data_we),
        .waddr (idx_reg),
        .wdata (data_wdata),
        .re    (rd_en),
        .raddr (head_idx),
        .rdata (data_rdata)
    );

    // unpack the entry read for the current request
    always_comb
    begin
        held_valid = tag_rdata[dptt_pkg::SIG_W];
        held_sig   = tag_rdata[dptt_pkg::SIG_W-1:0];
        held_move  = data_rdata[dptt_pkg::INFO_W +: dptt_pkg::MOVE_W];
        held_depth = data_rdata[dptt_pkg::INFO_DEPTH_LSB +: dptt_pkg::DEPTH_W];
        held_bound = data_rdata[dptt_pkg::INFO_BOUND_LSB +: dptt_pkg::BOUND_W];
        held_score = $signed(data_rdata[dptt_pkg::SCORE_W-1:0]);
    end

    // replacement and probe decisions
    always_comb
    begin
        store_wins   = !held_valid || (held_depth <= item_reg.depth);
        hit          = held_valid && (held_sig == item_reg.sig);
        deep         = (held_depth >= item_reg.depth);
        usable       = 1'b0;
        usable_score = '0;
        priority if (held_bound == dptt_pkg::BOUND_EXACT)
        begin
            usable       = 1'b1;
            usable_score = held_score;
        end
        else if (held_bound == dptt_pkg::BOUND_ALPHA && held_score <= item_reg.alpha)
        begin
            usable       = 1'b1;
            usable_score = item_reg.alpha;
        end
        else if (held_bound == dptt_pkg::BOUND_BETA && held_score >= item_reg.beta)
        begin
            usable       = 1'b1;
            usable_score = item_reg.beta;
        end
        else
        begin
            usable       = 1'b0;
            usable_score = '0;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            dptt_pkg::BK_CLEAR:
            begin
                if (clr_cnt_reg == IDX_W'(TABLE_ENTRIES - 1))
                begin
                    state_next = dptt_pkg::BK_IDLE;
                end
            end
            dptt_pkg::BK_IDLE:
            begin
                if (!q_empty)
                begin
                    if (head_item.op == dptt_pkg::OP_CLEAR)
                    begin
                        state_next = dptt_pkg::BK_CLEAR;
                    end
                    else
                    begin
                        state_next = dptt_pkg::BK_EXEC;
                    end
                end
            end
            dptt_pkg::BK_EXEC:
            begin
                state_next = dptt_pkg::BK_IDLE;
            end
            default:
            begin
                state_next = dptt_pkg::BK_CLEAR;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        q_pop             = 1'b0;
        rd_en             = 1'b0;
        tag_we            = 1'b0;
        tag_waddr         = idx_reg;
        tag_wdata         = {1'b1, item_reg.sig};
        data_we           = 1'b0;
        data_wdata        = {item_reg.move, item_reg.depth, item_reg.bound, item_reg.score};
        clr_cnt_next      = clr_cnt_reg;
        item_next         = item_reg;
        idx_next          = idx_reg;
        res_valid_next    = 1'b0;
        score_known_next  = 1'b0;
        result_score_next = '0;
        move_known_next   = 1'b0;
        hash_move_next    = '0;
        unique case (state_reg)
            dptt_pkg::BK_CLEAR:
            begin
                // sweep one entry a cycle, writing it empty
                tag_we    = 1'b1;
                tag_waddr = clr_cnt_reg;
                tag_wdata = '0;
                if (clr_cnt_reg == IDX_W'(TABLE_ENTRIES - 1))
                begin
                    clr_cnt_next = '0;
                end
                else
                begin
                    clr_cnt_next = clr_cnt_reg + 1'b1;
                end
            end
            dptt_pkg::BK_IDLE:
            begin
                // take the head item and start its entry read
                q_pop = !q_empty;
                rd_en = !q_empty;
                if (!q_empty)
                begin
                    item_next = head_item;
                    idx_next  = head_idx;
                end
            end
            dptt_pkg::BK_EXEC:
            begin
                if (item_reg.op == dptt_pkg::OP_STORE)
                begin
                    tag_we  = store_wins;
                    data_we = store_wins;
                end
                else if (item_reg.op == dptt_pkg::OP_LOAD)
                begin
                    res_valid_next = 1'b1;
                    if (hit)
                    begin
                        if (deep && usable)
                        begin
                            score_known_next  = 1'b1;
                            result_score_next = usable_score;
                        end
                        else
                        begin
                            move_known_next = 1'b1;
                            hash_move_next  = held_move;
                        end
                    end
                end
            end
            default:
            begin
                q_pop = 1'b0;
            end
        endcase
    end

    // control registers, reset starts the clear sweep
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= dptt_pkg::BK_CLEAR;
            clr_cnt_reg   <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        item_reg         <= item_next;
        idx_reg          <= idx_next;
        score_known_reg  <= score_known_next;
        result_score_reg <= result_score_next;
        move_known_reg   <= move_known_next;
        hash_move_reg    <= hash_move_next;
    end

    assign result_valid = res_valid_reg;
    assign score_known  = score_known_reg;
    assign result_score = result_score_reg;
    assign move_known   = move_known_reg;
    assign hash_move    = hash_move_reg;

endmodule
